[design/srpc_pkg.sv]
package srpc_pkg;

  localparam int unsigned RATE_W   = 16;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned MODE_W   = 6;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned STATE_W  = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [RATE_W-1:0] RATE_MAX = '1;

  // command codes
  localparam logic [CMD_W-1:0] CMD_TICK      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STOP      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_EMERGENCY = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REDUCE_SN = 3'd4;
  localparam logic [CMD_W-1:0] CMD_STOP_SN   = 3'd5;
  localparam logic [CMD_W-1:0] CMD_BRAKE_DN  = 3'd6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_PPS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_STEP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_PPS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REDUCE_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_PPS      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_PULSES = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REDUCE_PULSE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MODE         = 3'd7;

  // mode bit positions
  localparam int unsigned MODE_PULSE_CNT  = 0;
  localparam int unsigned MODE_NO_RELEASE = 1;
  localparam int unsigned MODE_CHK_STOP   = 2;
  localparam int unsigned MODE_CHK_START  = 3;
  localparam int unsigned MODE_DIR        = 4;
  localparam int unsigned MODE_BRAKE_DLY  = 5;

  // motor state codes as seen on the result channel
  localparam logic [STATE_W-1:0] ST_BRAKING = 4'd6;
  localparam logic [STATE_W-1:0] ST_STOP    = 4'd8;
  localparam logic [STATE_W-1:0] ST_GAIN    = 4'd1;
  localparam logic [STATE_W-1:0] ST_CONST   = 4'd2;

  typedef struct packed {
    logic [STATE_W-1:0] motor_state;
    logic [RATE_W-1:0]  pulse_rate;
    logic               rate_write;
    logic               direction;
    logic               brake_now;
    logic               release_now;
    logic               start_brake_delay;
    logic               fault;
    logic               start_rejected;
    logic [COUNT_W-1:0] pulse_target;
  } srpc_res_t;

endpackage

[design/srpc_in_if.sv]
interface srpc_in_if;
  logic                         valid;
  logic                         ready;
  logic [srpc_pkg::CMD_W-1:0]   cmd;
  logic                         sensor_level;
  logic [srpc_pkg::COUNT_W-1:0] pulse_count;
  logic                         start_sensor_on;
  logic                         reduce_sensor_on;
  logic                         stop_sensor_on;

  modport source (output valid, cmd, sensor_level, pulse_count, start_sensor_on,
                  reduce_sensor_on, stop_sensor_on, input ready);
  modport sink (input valid, cmd, sensor_level, pulse_count, start_sensor_on,
                reduce_sensor_on, stop_sensor_on, output ready);
endinterface

[design/srpc_out_if.sv]
interface srpc_out_if;
  logic                         valid;
  logic                         ready;
  logic [srpc_pkg::STATE_W-1:0] motor_state;
  logic [srpc_pkg::RATE_W-1:0]  pulse_rate;
  logic                         rate_write;
  logic                         direction;
  logic                         brake_now;
  logic                         release_now;
  logic                         start_brake_delay;
  logic                         fault;
  logic                         start_rejected;
  logic [srpc_pkg::COUNT_W-1:0] pulse_target;

  modport source (output valid, motor_state, pulse_rate, rate_write, direction,
                  brake_now, release_now, start_brake_delay, fault, start_rejected,
                  pulse_target, input ready);
  modport sink (input valid, motor_state, pulse_rate, rate_write, direction,
                brake_now, release_now, start_brake_delay, fault, start_rejected,
                pulse_target, output ready);
endinterface

[design/srpc_cfg_if.sv]
interface srpc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [srpc_pkg::CFG_IDX_W-1:0]  index;
  logic [srpc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[design/stepper_position_ramp_controller.sv]
// Trapezoidal ramp controller for a stepper axis. One request carries one command
// (tick, start, stop, emergency, reduce/stop sensor edge, brake timer done) and
// yields exactly one result holding the motor state after the command, the
// commanded pulse rate and one-shot action strobes (rate write, brake, release,
// brake delay start). Requests are registered, evaluated by a single pass of
// compare/add logic against the profile state, and the result is registered, so
// a new request is taken every cycle while the result side keeps up. Profile
// registers are written through the cfg channel, which is always ready, and must
// only be changed while no request is in flight.
module stepper_position_ramp_controller (
  input logic       clk,
  input logic       rst_n,
  srpc_in_if.sink   in_ch,
  srpc_out_if.source out_ch,
  srpc_cfg_if.sink  cfg_ch
);
  import srpc_pkg::*;

  typedef enum logic [STATE_W-1:0] {
    PH_IDLE     = 4'd0,
    PH_GAIN     = 4'd1,
    PH_CONST    = 4'd2,
    PH_REDUCE   = 4'd3,
    PH_LOWC     = 4'd4,
    PH_BRAKE    = 4'd5,
    PH_BRAKING  = 4'd6,
    PH_STOPPING = 4'd7,
    PH_STOP     = 4'd8
  } phase_t;

  // profile registers
  logic [RATE_W-1:0]  start_pps_r, gain_step_r, high_pps_r, reduce_step_r, low_pps_r;
  logic [COUNT_W-1:0] total_pulses_r, reduce_pulse_r;
  logic [MODE_W-1:0]  mode_r;

  // input register stage
  logic               s1_vld_r;
  logic [CMD_W-1:0]   cmd_r;
  logic               level_r;
  logic [COUNT_W-1:0] pulses_r;
  logic               sn_start_r, sn_reduce_r, sn_stop_r;

  // profile state
  phase_t             phase_r, phase_nxt;
  logic [RATE_W-1:0]  rate_r, rate_nxt;
  logic               fault_r, fault_nxt;
  logic               dir_r, dir_nxt;

  // result register
  logic               out_vld_r;
  srpc_res_t          res_r, res_nxt;

  logic out_free, s1_fire, in_fire;

  assign out_free = !out_vld_r || out_ch.ready;
  assign s1_fire  = s1_vld_r && out_free;
  assign in_ch.ready = !s1_vld_r || out_free;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_pps_r    <= '0;
      gain_step_r    <= '0;
      high_pps_r     <= '0;
      reduce_step_r  <= '0;
      low_pps_r      <= '0;
      total_pulses_r <= '0;
      reduce_pulse_r <= '0;
      mode_r         <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_START_PPS:    start_pps_r    <= cfg_ch.data[RATE_W-1:0];
        REG_GAIN_STEP:    gain_step_r    <= cfg_ch.data[RATE_W-1:0];
        REG_HIGH_PPS:     high_pps_r     <= cfg_ch.data[RATE_W-1:0];
        REG_REDUCE_STEP:  reduce_step_r  <= cfg_ch.data[RATE_W-1:0];
        REG_LOW_PPS:      low_pps_r      <= cfg_ch.data[RATE_W-1:0];
        REG_TOTAL_PULSES: total_pulses_r <= cfg_ch.data[COUNT_W-1:0];
        REG_REDUCE_PULSE: reduce_pulse_r <= cfg_ch.data[COUNT_W-1:0];
        REG_MODE:         mode_r         <= cfg_ch.data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // input request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r       <= in_ch.cmd;
      level_r     <= in_ch.sensor_level;
      pulses_r    <= in_ch.pulse_count;
      sn_start_r  <= in_ch.start_sensor_on;
      sn_reduce_r <= in_ch.reduce_sensor_on;
      sn_stop_r   <= in_ch.stop_sensor_on;
    end
  end

  // single-pass evaluation of the registered request
  logic [RATE_W:0]   gain_sum, reduce_floor;
  logic [RATE_W-1:0] r;
  phase_t            ph;
  logic              wr, brk, rel, bdel, rej;
  logic [COUNT_W-1:0] target;

  assign gain_sum     = {1'b0, rate_r} + {1'b0, gain_step_r};
  assign reduce_floor = {1'b0, low_pps_r} + {1'b0, reduce_step_r};

  always_comb begin
    phase_nxt = phase_r;
    rate_nxt  = rate_r;
    fault_nxt = fault_r;
    dir_nxt   = dir_r;
    r         = rate_r;
    ph        = phase_r;
    wr        = 1'b0;
    brk       = 1'b0;
    rel       = 1'b0;
    bdel      = 1'b0;
    rej       = 1'b0;
    target    = '0;

    case (cmd_r)
      CMD_TICK: begin
        if (phase_r != PH_IDLE && phase_r != PH_STOP) begin
          // ramp step
          if (phase_r == PH_GAIN) begin
            if (rate_r >= high_pps_r) begin
              r  = high_pps_r;
              ph = PH_CONST;
            end else begin
              r = gain_sum[RATE_W] ? RATE_MAX : gain_sum[RATE_W-1:0];
            end
          end else if (phase_r == PH_REDUCE) begin
            if (reduce_step_r == '0) begin
              if (mode_r[MODE_PULSE_CNT]) begin
                r  = low_pps_r;
                ph = PH_LOWC;
              end else begin
                r  = '0;
                ph = PH_BRAKE;
              end
            end else if ({1'b0, rate_r} > reduce_floor) begin
              r = rate_r - reduce_step_r;
            end else if (rate_r != '0) begin
              r  = low_pps_r;
              ph = PH_LOWC;
            end
          end
          // pulse-count limits override the ramp
          if (mode_r[MODE_PULSE_CNT]) begin
            if (pulses_r >= total_pulses_r) begin
              r = '0;
              if (ph < PH_BRAKE) ph = PH_BRAKE;
            end else if (pulses_r >= reduce_pulse_r) begin
              if (ph < PH_REDUCE) ph = PH_REDUCE;
            end
          end
          if (r != rate_r) begin
            wr       = (r != '0);
            rate_nxt = r;
          end
          // brake, optional delay, then release and finish check
          if (ph == PH_BRAKE) begin
            brk = 1'b1;
            if (mode_r[MODE_BRAKE_DLY]) begin
              bdel = 1'b1;
              ph   = PH_BRAKING;
            end else begin
              ph = PH_STOPPING;
            end
          end
          if (ph == PH_STOPPING) begin
            rel = !mode_r[MODE_NO_RELEASE];
            ph  = PH_STOP;
            if (mode_r[MODE_CHK_STOP] && !sn_stop_r) fault_nxt = 1'b1;
          end
          phase_nxt = ph;
        end
      end
      CMD_START: begin
        if (mode_r[MODE_CHK_START] && (!sn_start_r || sn_reduce_r || sn_stop_r)) begin
          rej = 1'b1;
        end else begin
          dir_nxt = mode_r[MODE_DIR];
          if (gain_step_r != '0) begin
            rate_nxt  = start_pps_r;
            phase_nxt = PH_GAIN;
          end else begin
            rate_nxt  = high_pps_r;
            phase_nxt = PH_CONST;
          end
          wr        = (rate_nxt != '0);
          fault_nxt = 1'b0;
          target    = mode_r[MODE_PULSE_CNT] ? total_pulses_r : '0;
        end
      end
      CMD_STOP: begin
        if (phase_r != PH_IDLE) phase_nxt = PH_REDUCE;
      end
      CMD_EMERGENCY: begin
        phase_nxt = PH_BRAKE;
      end
      CMD_REDUCE_SN: begin
        if (phase_r != PH_IDLE && phase_r < PH_REDUCE && level_r) phase_nxt = PH_REDUCE;
      end
      CMD_STOP_SN: begin
        if (phase_r != PH_IDLE && phase_r < PH_BRAKE && level_r) phase_nxt = PH_BRAKE;
      end
      CMD_BRAKE_DN: begin
        if (phase_r == PH_BRAKING) phase_nxt = PH_STOPPING;
      end
      default: ;
    endcase

    res_nxt.motor_state       = phase_nxt;
    res_nxt.pulse_rate        = rate_nxt;
    res_nxt.rate_write        = wr;
    res_nxt.direction         = dir_nxt;
    res_nxt.brake_now         = brk;
    res_nxt.release_now       = rel;
    res_nxt.start_brake_delay = bdel;
    res_nxt.fault             = fault_nxt;
    res_nxt.start_rejected    = rej;
    res_nxt.pulse_target      = target;
  end

  // profile state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      rate_r    <= '0;
      fault_r   <= 1'b0;
      dir_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (s1_fire) begin
        phase_r <= phase_nxt;
        rate_r  <= rate_nxt;
        fault_r <= fault_nxt;
        dir_r   <= dir_nxt;
      end
      if (out_free) out_vld_r <= s1_vld_r;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (s1_fire) res_r <= res_nxt;
  end

  assign out_ch.valid             = out_vld_r;
  assign out_ch.motor_state       = res_r.motor_state;
  assign out_ch.pulse_rate        = res_r.pulse_rate;
  assign out_ch.rate_write        = res_r.rate_write;
  assign out_ch.direction         = res_r.direction;
  assign out_ch.brake_now         = res_r.brake_now;
  assign out_ch.release_now       = res_r.release_now;
  assign out_ch.start_brake_delay = res_r.start_brake_delay;
  assign out_ch.fault             = res_r.fault;
  assign out_ch.start_rejected    = res_r.start_rejected;
  assign out_ch.pulse_target      = res_r.pulse_target;

endmodule

[design/srpc_chk.sv]
module srpc_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [srpc_pkg::STATE_W-1:0] out_motor_state,
  input logic [srpc_pkg::RATE_W-1:0]  out_pulse_rate,
  input logic                         out_rate_write,
  input logic                         out_brake_now,
  input logic                         out_release_now,
  input logic                         out_start_rejected,
  input logic [srpc_pkg::COUNT_W-1:0] out_pulse_target
);
  import srpc_pkg::*;

  // a stalled result keeps its state and rate
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_motor_state)
      && $stable(out_pulse_rate))
    else $error("result changed while stalled");

  // a rate write always carries a nonzero rate
  a_wr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rate_write |-> out_pulse_rate != '0)
    else $error("rate write with zero rate");

  // braking always ends in the delay wait or in the stop state
  a_brake_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_brake_now |-> out_motor_state == ST_BRAKING || out_motor_state == ST_STOP)
    else $error("brake strobe in wrong state");

  // release only when the motion has finished
  a_release_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_release_now |-> out_motor_state == ST_STOP)
    else $error("release strobe before stop");

  // a refused start causes no other action
  a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_start_rejected |-> !out_rate_write && !out_brake_now
      && out_pulse_target == '0)
    else $error("rejected start caused an action");

endmodule

bind stepper_position_ramp_controller srpc_chk u_srpc_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_motor_state    (out_ch.motor_state),
  .out_pulse_rate     (out_ch.pulse_rate),
  .out_rate_write     (out_ch.rate_write),
  .out_brake_now      (out_ch.brake_now),
  .out_release_now    (out_ch.release_now),
  .out_start_rejected (out_ch.start_rejected),
  .out_pulse_target   (out_ch.pulse_target)
);
